@@ src/rhsv_pkg.sv @@
package rhsv_pkg;

  localparam int ChanW       = 8;
  // One quotient bit per divider stage; both quotients fit in a channel.
  localparam int DivSteps    = ChanW;
  localparam int FrontStages = 3;
  localparam int PipeStages  = FrontStages + DivSteps;

  // 255*c < 2^16, and 6c <= 1530 needs 11 bits.
  localparam int SatNumW = 2 * ChanW;
  localparam int HueDivW = ChanW + 3;
  localparam int HueNumW = HueDivW + ChanW;
  // Signed position inside the hexagon before wrap.
  localparam int PosW    = HueDivW + 1;
  localparam int DiffW   = ChanW + 1;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [ChanW-1:0] hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] brightness;
  } hsv_t;

endpackage

@@ src/rgb_to_hsv_pixel_top.sv @@
// Pipeline: three front stages for max/min, hexagon position and numerators, then
// eight one-bit restoring divider stages for saturation and hue side by side.
// Throughput: one pixel per clock while out_stall is low; every stage advances on
// its own when empty.
// Reset (rst_n low at a clock edge) clears the stage valid bits; data is not reset.
module rgb_to_hsv_pixel_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rhsv_pkg::rgb_t     in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rhsv_pkg::hsv_t     out_data
);

  localparam int ChanW    = rhsv_pkg::ChanW;
  localparam int DivSteps = rhsv_pkg::DivSteps;
  localparam int FrontN   = rhsv_pkg::FrontStages;
  localparam int NStages  = rhsv_pkg::PipeStages;
  localparam int SatNumW  = rhsv_pkg::SatNumW;
  localparam int HueDivW  = rhsv_pkg::HueDivW;
  localparam int HueNumW  = rhsv_pkg::HueNumW;
  localparam int PosW     = rhsv_pkg::PosW;
  localparam int DiffW    = rhsv_pkg::DiffW;

  typedef enum logic [1:0] {
    SecRed,
    SecGreen,
    SecBlue
  } sector_t;

  logic [NStages-1:0] v_r;
  logic [NStages-1:0] adv;

  // A stage takes new contents when it is empty or its contents move on.
  assign adv[NStages-1] = !v_r[NStages-1] || !out_stall;
  for (genvar k = 0; k < NStages - 1; k++) begin : g_adv
    assign adv[k] = !v_r[k] || adv[k+1];
  end

  assign in_stall  = !adv[0];
  assign out_valid = v_r[NStages-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NStages; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: max, min, sector and in-sector difference
  logic [ChanW-1:0] mx_nxt, mn_nxt;
  sector_t          sec_nxt;
  logic [DiffW-1:0] diff_nxt;

  logic [ChanW-1:0] s1_mx_r, s1_mn_r;
  sector_t          s1_sec_r;
  logic [DiffW-1:0] s1_diff_r;

  always_comb begin
    logic [ChanW-1:0] r, g, b;
    r = in_data.red;
    g = in_data.green;
    b = in_data.blue;
    // Ties resolve to blue, then green, then red.
    if (b >= r && b >= g) begin
      sec_nxt  = SecBlue;
      mx_nxt   = b;
      diff_nxt = DiffW'(r) - DiffW'(g);
    end else if (g >= r) begin
      sec_nxt  = SecGreen;
      mx_nxt   = g;
      diff_nxt = DiffW'(b) - DiffW'(r);
    end else begin
      sec_nxt  = SecRed;
      mx_nxt   = r;
      diff_nxt = DiffW'(g) - DiffW'(b);
    end
    mn_nxt = r;
    if (g < mn_nxt) mn_nxt = g;
    if (b < mn_nxt) mn_nxt = b;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_mx_r   <= mx_nxt;
      s1_mn_r   <= mn_nxt;
      s1_sec_r  <= sec_nxt;
      s1_diff_r <= diff_nxt;
    end
  end

  // Stage 2: chroma, full turn 6c and wrapped hexagon position
  logic [ChanW-1:0]   c_nxt;
  logic [HueDivW-1:0] six_c_nxt;
  logic [HueDivW-1:0] pos_nxt;

  logic [ChanW-1:0]   s2_mx_r, s2_c_r;
  logic [HueDivW-1:0] s2_six_c_r, s2_pos_r;

  always_comb begin
    logic [PosW-1:0] offc;
    logic [PosW-1:0] raw;
    c_nxt     = s1_mx_r - s1_mn_r;
    six_c_nxt = HueDivW'({c_nxt, 2'b00}) + HueDivW'({c_nxt, 1'b0});
    case (s1_sec_r)
      SecGreen: offc = PosW'({c_nxt, 1'b0});
      SecBlue:  offc = PosW'({c_nxt, 2'b00});
      default:  offc = '0;
    endcase
    raw = offc + {{(PosW - DiffW){s1_diff_r[DiffW-1]}}, s1_diff_r};
    // Only the red sector can go negative: add a full turn.
    if (raw[PosW-1]) begin
      raw = raw + PosW'(six_c_nxt);
    end
    pos_nxt = raw[HueDivW-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_mx_r    <= s1_mx_r;
      s2_c_r     <= c_nxt;
      s2_six_c_r <= six_c_nxt;
      s2_pos_r   <= pos_nxt;
    end
  end

  // Stage 3: numerators scaled by 255
  logic [ChanW-1:0]   s3_mx_r;
  logic [HueDivW-1:0] s3_six_c_r;
  logic [SatNumW-1:0] s3_snum_r;
  logic [HueNumW-1:0] s3_hnum_r;
  logic               s3_zero_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_mx_r    <= s2_mx_r;
      s3_six_c_r <= s2_six_c_r;
      s3_snum_r  <= {s2_c_r, {ChanW{1'b0}}} - SatNumW'(s2_c_r);
      s3_hnum_r  <= {s2_pos_r, {ChanW{1'b0}}} - HueNumW'(s2_pos_r);
      s3_zero_r  <= (s2_c_r == '0);
    end
  end

  // Divider stages: one quotient bit of each division per stage, MSB first
  logic [SatNumW-1:0] srem_r [DivSteps];
  logic [HueNumW-1:0] hrem_r [DivSteps];
  logic [ChanW-1:0]   sdiv_r [DivSteps];
  logic [HueDivW-1:0] hdiv_r [DivSteps];
  logic [ChanW-1:0]   sq_r   [DivSteps];
  logic [ChanW-1:0]   hq_r   [DivSteps];
  logic               zero_r [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    localparam int Sh = DivSteps - 1 - k;

    logic [SatNumW-1:0] srem_in, srem_nxt, sdsh;
    logic [HueNumW-1:0] hrem_in, hrem_nxt, hdsh;
    logic [ChanW-1:0]   sdiv_in, sq_in, sq_nxt, hq_in, hq_nxt;
    logic [HueDivW-1:0] hdiv_in;
    logic               zero_in;

    if (k == 0) begin : g_first
      assign srem_in = s3_snum_r;
      assign hrem_in = s3_hnum_r;
      assign sdiv_in = s3_mx_r;
      assign hdiv_in = s3_six_c_r;
      assign sq_in   = '0;
      assign hq_in   = '0;
      assign zero_in = s3_zero_r;
    end else begin : g_next
      assign srem_in = srem_r[k-1];
      assign hrem_in = hrem_r[k-1];
      assign sdiv_in = sdiv_r[k-1];
      assign hdiv_in = hdiv_r[k-1];
      assign sq_in   = sq_r[k-1];
      assign hq_in   = hq_r[k-1];
      assign zero_in = zero_r[k-1];
    end

    assign sdsh = SatNumW'(sdiv_in) << Sh;
    assign hdsh = HueNumW'(hdiv_in) << Sh;

    always_comb begin
      srem_nxt = srem_in;
      sq_nxt   = sq_in;
      if (srem_in >= sdsh) begin
        srem_nxt   = srem_in - sdsh;
        sq_nxt[Sh] = 1'b1;
      end
      hrem_nxt = hrem_in;
      hq_nxt   = hq_in;
      if (hrem_in >= hdsh) begin
        hrem_nxt   = hrem_in - hdsh;
        hq_nxt[Sh] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[FrontN+k]) begin
        srem_r[k] <= srem_nxt;
        hrem_r[k] <= hrem_nxt;
        sdiv_r[k] <= sdiv_in;
        hdiv_r[k] <= hdiv_in;
        sq_r[k]   <= sq_nxt;
        hq_r[k]   <= hq_nxt;
        zero_r[k] <= zero_in;
      end
    end
  end

  // Zero chroma (grey or black) divides by zero above: force hue and saturation to 0.
  assign out_data.hue        = zero_r[DivSteps-1] ? '0 : hq_r[DivSteps-1];
  assign out_data.saturation = zero_r[DivSteps-1] ? '0 : sq_r[DivSteps-1];
  assign out_data.brightness = sdiv_r[DivSteps-1];

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hue != {ChanW{1'b1}})
    else $error("hue reached a full turn");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.brightness == '0 |->
      out_data.saturation == '0 && out_data.hue == '0)
    else $error("black pixel with nonzero hue or saturation");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r) && out_stall)
    else $error("input stalled with room in the pipeline");

endmodule
